FILE: rtl/rdf_pkg.sv
// Shared types and constants for the radix digit formatter.
// No dependencies; used by radix_digit_formatter.
package rdf_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } fmt_state_type;

   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned BASE_W     = 5;
   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned DIGIT_W    = 4;
   // quotient bits retired by the divider per cycle
   localparam int unsigned DIV_BITS   = 4;
   localparam int unsigned DIV_STEPS  = VALUE_W / DIV_BITS;
   localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

   localparam logic [CHAR_W-1:0] CH_SPACE     = CHAR_W'(32);
   localparam logic [CHAR_W-1:0] CH_POINT     = CHAR_W'(46);
   localparam logic [CHAR_W-1:0] CH_ZERO      = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = CHAR_W'(55);

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_W'(10)) begin
         c = CH_ZERO + CHAR_W'(d);
      end else begin
         c = CH_ALPHA_OFS + CHAR_W'(d);
      end
      return c;
   endfunction

endpackage

FILE: rtl/radix_digit_formatter.sv
// Radix digit formatter: unsigned Q32.32 value to a fixed ASCII field.
// Depends on rdf_pkg.
//
// Each accepted item yields INT_DIGITS + 1 + FRAC_DIGITS characters (41 by
// default), one per transfer, integer digits right-aligned and space-padded,
// then '.' (or a space when the fraction is zero), then fraction digits and
// trailing spaces. Base is saturated to 2..16. An item first converts its
// integer part, one to INT_DIGITS digits, then emits its characters, which
// wait while the result side does not keep up. The integer digits come
// from one shared restoring divider that retires four quotient bits a
// cycle; fraction digits come from one 32x5 multiply per character.
// req_ready is high only in the idle state, which is entered once the last
// character of an item is loaded into the output register.
// int_overflow is set on every character when the integer needs more than
// INT_DIGITS digits; only the low digits are then shown.
module radix_digit_formatter #(
   parameter int unsigned INT_DIGITS  = 20,
   parameter int unsigned FRAC_DIGITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rdf_pkg::VALUE_W-1:0]   req_value_int,
   input  logic [rdf_pkg::VALUE_W-1:0]   req_value_frac,
   input  logic [rdf_pkg::BASE_W-1:0]    req_base,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdf_pkg::CHAR_W-1:0]    rsp_digit_char,
   output logic                          rsp_last_char,
   output logic                          rsp_int_overflow
);

   localparam int unsigned FIELD_LEN = INT_DIGITS + 1 + FRAC_DIGITS;
   localparam int unsigned CNT_W     = $clog2(FIELD_LEN + 1);
   localparam int unsigned IDX_W     = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;

   rdf_pkg::fmt_state_type state_ff, state_in;

   logic [rdf_pkg::BASE_W-1:0]  base_ff, base_in;
   logic [rdf_pkg::VALUE_W-1:0] work_ff, work_in;
   logic [rdf_pkg::BASE_W-1:0]  rem_ff, rem_in;
   logic [rdf_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]            ndig_ff, ndig_in;
   logic                        ovf_ff, ovf_in;
   logic [rdf_pkg::VALUE_W-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]            pos_ff, pos_in;
   logic [rdf_pkg::DIGIT_W-1:0] digit_ff [INT_DIGITS];

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rdf_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   // control
   logic accept, div_en, div_done, int_done, load, pos_last;

   // divider step
   logic [rdf_pkg::VALUE_W-1:0] step_work;
   logic [rdf_pkg::BASE_W-1:0]  step_rem;
   logic [CNT_W-1:0]            wr_slot;
   logic [IDX_W-1:0]            wr_idx;

   // emit
   logic [rdf_pkg::VALUE_W+rdf_pkg::BASE_W-1:0] prod;
   logic [CNT_W:0]                              lead_sum;
   logic [rdf_pkg::BASE_W-1:0]                  base_sat;

   // restoring division, DIV_BITS quotient bits per cycle
   always_comb begin
      logic [rdf_pkg::BASE_W-1:0] t;
      step_work = work_ff;
      step_rem  = rem_ff;
      for (int i = 0; i < int'(rdf_pkg::DIV_BITS); i++) begin
         t = {step_rem[rdf_pkg::BASE_W-2:0], step_work[rdf_pkg::VALUE_W-1]};
         if (t >= base_ff) begin
            step_rem  = t - base_ff;
            step_work = {step_work[rdf_pkg::VALUE_W-2:0], 1'b1};
         end else begin
            step_rem  = t;
            step_work = {step_work[rdf_pkg::VALUE_W-2:0], 1'b0};
         end
      end
   end

   assign div_done = (step_ff == rdf_pkg::STEP_W'(rdf_pkg::DIV_STEPS - 1));
   assign int_done = div_done &&
                     ((step_work == '0) || (ndig_ff + CNT_W'(1) == CNT_W'(INT_DIGITS)));
   assign wr_slot  = CNT_W'(INT_DIGITS - 1) - ndig_ff;
   assign wr_idx   = wr_slot[IDX_W-1:0];
   assign pos_last = (pos_ff == CNT_W'(FIELD_LEN - 1));
   assign prod     = (rdf_pkg::VALUE_W + rdf_pkg::BASE_W)'(frac_ff) *
                     (rdf_pkg::VALUE_W + rdf_pkg::BASE_W)'(base_ff);
   assign lead_sum = (CNT_W + 1)'(pos_ff) + (CNT_W + 1)'(ndig_ff);

   always_comb begin
      if (req_base < rdf_pkg::BASE_MIN) begin
         base_sat = rdf_pkg::BASE_MIN;
      end else if (req_base > rdf_pkg::BASE_MAX) begin
         base_sat = rdf_pkg::BASE_MAX;
      end else begin
         base_sat = req_base;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rdf_pkg::ST_IDLE: begin
            if (req_valid) state_in = rdf_pkg::ST_DIV;
         end
         rdf_pkg::ST_DIV: begin
            if (int_done) state_in = rdf_pkg::ST_EMIT;
         end
         rdf_pkg::ST_EMIT: begin
            if (load && pos_last) state_in = rdf_pkg::ST_IDLE;
         end
         default: state_in = rdf_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      div_en    = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         rdf_pkg::ST_IDLE: req_ready = 1'b1;
         rdf_pkg::ST_DIV:  div_en    = 1'b1;
         rdf_pkg::ST_EMIT: load      = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   // datapath next values
   always_comb begin
      base_in      = base_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      ndig_in      = ndig_ff;
      ovf_in       = ovf_ff;
      frac_in      = frac_ff;
      pos_in       = pos_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         base_in = base_sat;
         work_in = req_value_int;
         rem_in  = '0;
         step_in = '0;
         ndig_in = '0;
         frac_in = req_value_frac;
      end

      if (div_en) begin
         step_in = step_ff + rdf_pkg::STEP_W'(1);
         work_in = step_work;
         rem_in  = step_rem;
         if (div_done) begin
            // start the next digit on the quotient
            step_in = '0;
            rem_in  = '0;
            ndig_in = ndig_ff + CNT_W'(1);
            ovf_in  = (step_work != '0);
            pos_in  = '0;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = pos_last;
         rsp_ovf_in   = ovf_ff;
         pos_in       = pos_ff + CNT_W'(1);
         if (pos_ff < CNT_W'(INT_DIGITS)) begin
            if (lead_sum >= (CNT_W + 1)'(INT_DIGITS)) begin
               rsp_char_in = rdf_pkg::digit_to_ascii(digit_ff[pos_ff[IDX_W-1:0]]);
            end else begin
               rsp_char_in = rdf_pkg::CH_SPACE;
            end
         end else if (pos_ff == CNT_W'(INT_DIGITS)) begin
            rsp_char_in = (frac_ff != '0) ? rdf_pkg::CH_POINT : rdf_pkg::CH_SPACE;
         end else if (frac_ff != '0) begin
            rsp_char_in = rdf_pkg::digit_to_ascii(
                             prod[rdf_pkg::VALUE_W +: rdf_pkg::DIGIT_W]);
            frac_in     = prod[rdf_pkg::VALUE_W-1:0];
         end else begin
            rsp_char_in = rdf_pkg::CH_SPACE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      ndig_ff     <= ndig_in;
      ovf_ff      <= ovf_in;
      frac_ff     <= frac_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // integer digits, least significant first into the rightmost free slot
   always_ff @(posedge clock) begin
      if (div_en && div_done) begin
         digit_ff[wr_idx] <= step_rem[rdf_pkg::DIGIT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_char   = rsp_char_ff;
   assign rsp_last_char    = rsp_last_ff;
   assign rsp_int_overflow = rsp_ovf_ff;

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == rdf_pkg::ST_DIV) && (ndig_ff == '0) && (step_ff == '0))
      else $error("accepted item did not start integer conversion");

   a_div_digit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdf_pkg::ST_DIV) |-> (ndig_ff < CNT_W'(INT_DIGITS)))
      else $error("integer digit count ran past the field");

   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdf_pkg::ST_EMIT) |-> (ndig_ff != '0))
      else $error("emitting with no integer digit");

   a_ovf_full_field: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == rdf_pkg::ST_EMIT) && ovf_ff) |-> (ndig_ff == CNT_W'(INT_DIGITS)))
      else $error("overflow flagged before all integer slots were filled");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for radix_digit_formatter: Q32.32 value to a 41-character field.
// Depends on rdf_pkg and radix_digit_formatter; carries its own model of each field.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int INT_DIGITS  = 20;
   localparam int FRAC_DIGITS = 20;
   localparam int FIELD_LEN   = INT_DIGITS + 1 + FRAC_DIGITS;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 250;
   localparam int MAX_PRINTED = 30;

   typedef struct packed {
      logic [rdf_pkg::CHAR_W-1:0] glyph;
      logic                       last;
      logic                       ovf;
   } field_char_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [rdf_pkg::VALUE_W-1:0]   req_value_int = '0;
   logic [rdf_pkg::VALUE_W-1:0]   req_value_frac = '0;
   logic [rdf_pkg::BASE_W-1:0]    req_base = rdf_pkg::BASE_MIN;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [rdf_pkg::CHAR_W-1:0]    rsp_digit_char;
   logic                          rsp_last_char;
   logic                          rsp_int_overflow;

   field_char_type expected_chars[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int conversions_sent = 0;
   int chars_checked = 0;
   int overflow_fields = 0;
   int saturated_bases = 0;
   int stall_cycles = 0;

   radix_digit_formatter #(
      .INT_DIGITS (INT_DIGITS),
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value_int   (req_value_int),
      .req_value_frac  (req_value_frac),
      .req_base        (req_base),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_int_overflow(rsp_int_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [rdf_pkg::CHAR_W-1:0] digit_glyph(input logic [4:0] d);
      if (d < 5'd10) begin
         return rdf_pkg::CH_ZERO + rdf_pkg::CHAR_W'(d);
      end
      return rdf_pkg::CH_ALPHA_OFS + rdf_pkg::CHAR_W'(d);
   endfunction

   // Build the whole field for one conversion and append it to the queue.
   task automatic queue_field(input logic [31:0] vi, input logic [31:0] vf,
                              input logic [4:0] vb);
      logic [rdf_pkg::CHAR_W-1:0] glyphs [FIELD_LEN];
      logic [31:0] quot;
      logic [31:0] frac;
      logic [63:0] prod;
      logic [4:0]  b;
      logic        ovf;
      bit          done;
      field_char_type c;
      b = vb;
      if (b < rdf_pkg::BASE_MIN) b = rdf_pkg::BASE_MIN;
      if (b > rdf_pkg::BASE_MAX) b = rdf_pkg::BASE_MAX;
      for (int k = 0; k < FIELD_LEN; k++) glyphs[k] = rdf_pkg::CH_SPACE;
      quot = vi;
      done = 1'b0;
      for (int k = INT_DIGITS - 1; k >= 0 && !done; k--) begin
         glyphs[k] = digit_glyph(5'(quot % b));
         quot = quot / b;
         if (quot == 0) done = 1'b1;
      end
      ovf = (quot != 0);
      frac = vf;
      if (frac != 0) begin
         glyphs[INT_DIGITS] = rdf_pkg::CH_POINT;
         for (int k = INT_DIGITS + 1; k < FIELD_LEN && frac != 0; k++) begin
            prod = {32'd0, frac} * 64'(b);
            glyphs[k] = digit_glyph(prod[36:32]);
            frac = prod[31:0];
         end
      end
      for (int k = 0; k < FIELD_LEN; k++) begin
         c.glyph = glyphs[k];
         c.last  = (k == FIELD_LEN - 1);
         c.ovf   = ovf;
         expected_chars.push_back(c);
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < MAX_PRINTED) $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Present one conversion; valid stays up after the transfer so that a
   // back-to-back item never lowers and raises it in one step.
   task automatic send_conversion(input logic [31:0] vi, input logic [31:0] vf,
                                  input logic [4:0] vb);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_value_int  <= vi;
      req_value_frac <= vf;
      req_base       <= vb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queue_field(vi, vf, vb);
      conversions_sent++;
      if (vb < rdf_pkg::BASE_MIN || vb > rdf_pkg::BASE_MAX) saturated_bases++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      field_char_type exp_c;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_digit_char));
         end else begin
            exp_c = expected_chars.pop_front();
            chars_checked++;
            if (rsp_digit_char !== exp_c.glyph)
               report_mismatch($sformatf("digit_char got 0x%02h want 0x%02h",
                                         rsp_digit_char, exp_c.glyph));
            if (rsp_last_char !== exp_c.last)
               report_mismatch($sformatf("last_char got %b want %b",
                                         rsp_last_char, exp_c.last));
            if (rsp_int_overflow !== exp_c.ovf)
               report_mismatch($sformatf("int_overflow got %b want %b",
                                         rsp_int_overflow, exp_c.ovf));
            if (exp_c.last && exp_c.ovf) overflow_fields++;
         end
      end
   end

   // Abort when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("stalled for %0d cycles, %0d characters outstanding",
                     STALL_LIMIT, expected_chars.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic test_extremes();
      send_conversion(32'd0, 32'd0, 5'd10);
      send_conversion(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16);
      send_conversion(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd10);
      send_conversion(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2);
      send_conversion(32'h00AB_CDEF, 32'h1234_5678, 5'd16);
      send_conversion(32'd0, 32'd1, 5'd7);
      wait_drained();
   endtask

   task automatic test_overflow_boundary();
      send_conversion(32'h000F_FFFF, 32'd0, 5'd2);
      send_conversion(32'h0010_0000, 32'd0, 5'd2);
      send_conversion(32'd3486784400, 32'd0, 5'd3);
      send_conversion(32'd3486784401, 32'd0, 5'd3);
      wait_drained();
   endtask

   task automatic test_base_saturation();
      send_conversion(32'd12345, 32'h8000_0000, 5'd0);
      send_conversion(32'd12345, 32'h8000_0000, 5'd1);
      send_conversion(32'd12345, 32'h8000_0000, 5'd17);
      send_conversion(32'd12345, 32'h8000_0000, 5'd31);
      wait_drained();
   endtask

   task automatic test_fraction_cases();
      send_conversion(32'd1, 32'h8000_0000, 5'd2);
      send_conversion(32'd1, 32'h1999_9999, 5'd10);
      send_conversion(32'd9, 32'h5555_5555, 5'd3);
      send_conversion(32'd0, 32'hFFFF_FFFF, 5'd15);
      send_conversion(32'd42, 32'hC000_0000, 5'd4);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      logic [31:0] vi;
      logic [31:0] vf;
      logic [4:0]  vb;
      int sel;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(9);
         unique case (sel)
            0, 1, 2, 3: begin
               vi = $urandom_range(0, 999);
            end
            4, 5: begin
               vi = $urandom();
            end
            6: begin
               vi = $urandom() >> $urandom_range(0, 31);
            end
            7: begin
               vi = 32'd0;
            end
            default: begin
               vi = 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
         endcase
         sel = $urandom_range(9);
         unique case (sel)
            0, 1: begin
               vf = 32'd0;
            end
            2, 3, 4, 5: begin
               vf = $urandom();
            end
            6, 7, 8: begin
               // keep only the top bits so the fraction ends early
               vf = $urandom() & ~(32'hFFFF_FFFF >> $urandom_range(1, 12));
            end
            default: begin
               vf = 32'hFFFF_FFFF;
            end
         endcase
         if ($urandom_range(9) == 0) begin
            vb = 5'($urandom_range(0, 31));
         end else begin
            vb = 5'($urandom_range(2, 16));
         end
         send_conversion(vi, vf, vb);
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 35;
      recv_idle_pct = 68;
      test_extremes();
      test_overflow_boundary();
      test_base_saturation();
      test_fraction_cases();
      test_random(48, 35, 68);
      test_random(48, 68, 35);
      test_random(48, 0, 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
      $display("run covered %0d conversions, %0d characters, %0d fields with overflow",
               conversions_sent, chars_checked, overflow_fields);
      $display("bases drawn from 0..31, %0d out-of-range bases saturated, %0d mismatches",
               saturated_bases, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
